### rtl/core/hto_pkg.sv
// ----------------------------------------------------------------------------
// hto_pkg
// Shared types and codes for the hash table with a common overflow area.
// ----------------------------------------------------------------------------
package hto_pkg;

  localparam int KEY_W     = 15;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;

  // search probe travelling along the overflow cells
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic             found;
  } probe_t;

  // write command broadcast to the overflow cells
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [KEY_W-1:0] key;
  } cell_wr_t;

endpackage

### rtl/core/hto_if.sv
// ----------------------------------------------------------------------------
// hto_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface hto_in_if;
  import hto_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

interface hto_out_if;
  import hto_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                in_overflow;
  logic [SLOT_W-1:0]   slot;
  modport source (output valid, output status, output in_overflow, output slot, input ready);
  modport sink (input valid, input status, input in_overflow, input slot, output ready);
endinterface

### rtl/core/hash_table_overflow_area_top.sv
// ----------------------------------------------------------------------------
// hash_table_overflow_area_top
// Keyed table: remainder hashing into primary slots, shared overflow area.
// ----------------------------------------------------------------------------
// Each command beat (insert, lookup, remove) gives one result beat. One
// command is in work at a time. From accept to its result beat, the search
// probe walks the row of TABLE_SLOTS overflow cells one cell a cycle, its
// outcome is registered at the end of the row, the decision registers the
// result, and the result beat follows. The key remainder (a reciprocal
// multiply and a subtract) and the primary key read run beside the probe
// walk. A new command is taken while a result still waits on the output
// register. The overflow area fills in order; removed overflow slots are not
// reused, and an insert that meets a taken primary slot and a full overflow
// area is dropped with its own status.
module hash_table_overflow_area_top #(
  parameter int TABLE_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  hto_in_if.sink    in_if,
  hto_out_if.source out_if
);
  import hto_pkg::*;

  localparam int N  = TABLE_SLOTS;
  localparam int IW = $clog2(N);
  localparam int FW = $clog2(N + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [IW-1:0]     home_r;
  logic [KEY_W-1:0]  pkey_mem [N];
  logic [KEY_W-1:0]  pkey_rd_r;
  logic [N-1:0]      pvalid_r;
  logic [FW-1:0]     fill_r;
  probe_t            probe_in_r;
  probe_t            probe_w [N+1];
  logic [IW-1:0]     pidx_w [N+1];
  logic              chain_done_r;
  logic              ovf_hit_r;
  logic [IW-1:0]     ovf_idx_r;
  cell_wr_t          wcmd;
  logic [IW-1:0]     wsel;
  logic              in_fire;
  logic              rem_done;
  logic [IW-1:0]     rem;
  logic              dec;
  logic              pri_hit;
  logic              pk_we;
  logic              pv_set;
  logic              pv_clr;
  logic              fill_inc;
  logic [STATUS_W-1:0] res_status;
  logic              res_ovf;
  logic [IW-1:0]     res_idx;
  logic              out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic              out_ovf_r;
  logic [SLOT_W-1:0] out_slot_r;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  hto_rem #(.N(N)) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_fire),
    .key_i   (in_if.key),
    .done_o  (rem_done),
    .rem_o   (rem)
  );

  assign probe_w[0] = probe_in_r;
  assign pidx_w[0]  = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    hto_cell #(.N(N), .INDEX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .probe_i (probe_w[g]),
      .idx_i   (pidx_w[g]),
      .probe_o (probe_w[g+1]),
      .idx_o   (pidx_w[g+1]),
      .wcmd_i  (wcmd),
      .wsel_i  (wsel)
    );
  end

  assign dec     = (state_r == S_WAIT) && chain_done_r && (!out_valid_r || out_if.ready);
  assign pri_hit = pvalid_r[home_r] && (pkey_rd_r == key_r);

  always_comb begin
    res_status = ST_NOT_FOUND;
    res_ovf    = 1'b0;
    res_idx    = '0;
    pk_we      = 1'b0;
    pv_set     = 1'b0;
    pv_clr     = 1'b0;
    fill_inc   = 1'b0;
    wcmd.wr    = 1'b0;
    wcmd.clr   = 1'b0;
    wcmd.key   = key_r;
    wsel       = fill_r[IW-1:0];
    case (cmd_r)
      CMD_INSERT: begin
        if (!pvalid_r[home_r]) begin
          res_status = ST_INSERTED;
          res_idx    = home_r;
          pk_we      = dec;
          pv_set     = dec;
        end else if (fill_r < FW'(N)) begin
          res_status = ST_INSERTED;
          res_ovf    = 1'b1;
          res_idx    = fill_r[IW-1:0];
          wcmd.wr    = dec;
          fill_inc   = dec;
        end else begin
          res_status = ST_DROPPED;
        end
      end
      CMD_LOOKUP, CMD_REMOVE: begin
        if (pri_hit) begin
          res_status = (cmd_r == CMD_REMOVE) ? ST_REMOVED : ST_FOUND;
          res_idx    = home_r;
          pv_clr     = dec && (cmd_r == CMD_REMOVE);
        end else if (ovf_hit_r) begin
          res_status = (cmd_r == CMD_REMOVE) ? ST_REMOVED : ST_FOUND;
          res_ovf    = 1'b1;
          res_idx    = ovf_idx_r;
          wsel       = ovf_idx_r;
          wcmd.clr   = dec && (cmd_r == CMD_REMOVE);
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_HASH;
      S_HASH: if (rem_done) state_nxt = S_WAIT;
      S_WAIT: if (dec) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pvalid_r       <= '0;
      fill_r         <= '0;
      probe_in_r.vld <= 1'b0;
      chain_done_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      probe_in_r.vld <= in_fire;
      if (in_fire) begin
        chain_done_r <= 1'b0;
      end else if (probe_w[N].vld) begin
        chain_done_r <= 1'b1;
      end
      if (pv_set) begin
        pvalid_r[home_r] <= 1'b1;
      end else if (pv_clr) begin
        pvalid_r[home_r] <= 1'b0;
      end
      if (fill_inc) begin
        fill_r <= fill_r + 1'b1;
      end
      if (dec) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    probe_in_r.key   <= in_if.key;
    probe_in_r.found <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_if.cmd;
      key_r <= in_if.key;
    end
    if (probe_w[N].vld) begin
      ovf_hit_r <= probe_w[N].found;
      ovf_idx_r <= pidx_w[N];
    end
    if (dec) begin
      out_status_r <= res_status;
      out_ovf_r    <= res_ovf;
      out_slot_r   <= SLOT_W'(res_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (pk_we) begin
      pkey_mem[home_r] <= key_r;
    end
    if (rem_done) begin
      pkey_rd_r <= pkey_mem[rem];
      home_r    <= rem;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.in_overflow = out_ovf_r;
  assign out_if.slot        = out_slot_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(N))
    else $error("overflow fill count past table size");

  a_probe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    probe_w[N].vld |-> (state_r != S_IDLE))
    else $error("search probe left the chain with no command in work");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (dec && (res_status == ST_DROPPED)) |-> (fill_r == FW'(N)))
    else $error("insert dropped while overflow area has room");

  a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_HASH))
    else $error("accepted command did not start hashing");

endmodule

### rtl/core/hto_rem.sv
// ----------------------------------------------------------------------------
// hto_rem
// Key remainder by the slot count: reciprocal multiply, then subtract.
// ----------------------------------------------------------------------------
module hto_rem #(
  parameter int N = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [hto_pkg::KEY_W-1:0]    key_i,
  output logic                         done_o,
  output logic [$clog2(N)-1:0]         rem_o
);
  import hto_pkg::*;

  localparam int IW = $clog2(N);
  // quotient is floor(key * RECIP / 2**SH), exact over the whole key range
  localparam int SH = KEY_W + IW;
  localparam int MW = KEY_W + 2;
  localparam int PW = KEY_W + MW;
  localparam logic [MW-1:0]    RECIP   = MW'((2 ** SH + N - 1) / N);
  localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(N);

  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] quo;
  logic [KEY_W-1:0] back;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] quo_r;
  logic [IW-1:0]    rem_r;
  logic             stage_r;
  logic             done_r;

  assign prod = PW'(key_i) * PW'(RECIP);
  assign quo  = KEY_W'(prod >> SH);
  assign back = quo_r * DIVISOR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start_i;
      done_r  <= stage_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      key_r <= key_i;
      quo_r <= quo;
    end
    if (stage_r) begin
      rem_r <= IW'(key_r - back);
    end
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

### rtl/core/hto_cell.sv
// ----------------------------------------------------------------------------
// hto_cell
// One overflow slot: holds a key and its valid bit, checks the passing probe.
// ----------------------------------------------------------------------------
module hto_cell #(
  parameter int N     = 8,
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hto_pkg::probe_t         probe_i,
  input  logic [$clog2(N)-1:0]    idx_i,
  output hto_pkg::probe_t         probe_o,
  output logic [$clog2(N)-1:0]    idx_o,
  input  hto_pkg::cell_wr_t       wcmd_i,
  input  logic [$clog2(N)-1:0]    wsel_i
);
  import hto_pkg::*;

  localparam int IW = $clog2(N);

  logic [KEY_W-1:0] key_r;
  logic             valid_r;
  probe_t           probe_r;
  logic [IW-1:0]    idx_r;
  logic             sel;
  logic             hit;

  assign sel = (wsel_i == IW'(INDEX));
  assign hit = probe_i.vld && !probe_i.found && valid_r && (key_r == probe_i.key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      probe_r.vld <= 1'b0;
    end else begin
      if (sel && wcmd_i.wr) begin
        valid_r <= 1'b1;
      end else if (sel && wcmd_i.clr) begin
        valid_r <= 1'b0;
      end
      probe_r.vld <= probe_i.vld;
    end
    probe_r.key   <= probe_i.key;
    probe_r.found <= probe_i.found | hit;
  end

  always_ff @(posedge clk) begin
    if (sel && wcmd_i.wr) begin
      key_r <= wcmd_i.key;
    end
    idx_r <= hit ? IW'(INDEX) : idx_i;
  end

  assign probe_o = probe_r;
  assign idx_o   = idx_r;

endmodule
